@@ hdl/grld_pkg.sv @@
// shared types and constants for the gamma run-length decoder
// no dependencies; used by the controller, datapath, top level, checker and testbench
package grld_pkg;

    localparam int PIX_W   = 24;   // pixel_count register width
    localparam int LEN_W   = 26;   // run length and budget width
    localparam int BITS_W  = 4;    // holds a bit count of 0..8
    localparam logic [7:0] TOP_BIT = 8'h80;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE   = 1'b1;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       frame_start;
    } in_word_t;

    typedef struct packed {
        logic             run_color;
        logic [LEN_W-1:0] run_length;
        logic             run_last;
        logic             image_done;
        logic             length_error;
    } run_word_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [PIX_W-1:0]     value;
    } cfg_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;        // code bits left to decode in the current word
        logic emit;        // the current bit completes a run
        logic pend_valid;  // a descriptor waits for its run_last flag
        logic out_free;    // output register can take a descriptor now
    } stat_t;

endpackage

@@ hdl/grld_stream_if.sv @@
// valid/ready channel carrying one payload word of type T
// depends on nothing; payload types come from grld_pkg at instantiation
interface grld_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/grld_ctrl.sv @@
// sequencing state machine: accepts a word, steps its bits, flushes the last run
// depends on grld_pkg
module grld_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  grld_pkg::stat_t stat,
    output grld_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        cmd.load  = in_valid && ready_reg;
        cmd.step  = (state_reg == ST_BITS) && stat.busy
                    && (!stat.emit || !stat.pend_valid || stat.out_free);
        cmd.flush = (state_reg == ST_FLUSH) && stat.pend_valid && stat.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    state_next = ST_BITS;
                    ready_next = 1'b0;
                end
            end
            ST_BITS:
            begin
                if (!stat.busy)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

@@ hdl/grld_dp.sv @@
// datapath: config registers, bit shifter, prefix decoder, budget, run buffers
// depends on grld_pkg
module grld_dp #(
    parameter int MAX_ZEROS  = 24,
    parameter int PIXEL_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  grld_pkg::in_word_t   in_word,
    input  logic                 cfg_wr,
    input  grld_pkg::cfg_word_t  cfg_word,
    input  grld_pkg::cmd_t       cmd,
    output grld_pkg::stat_t      stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output grld_pkg::run_word_t  out_word
);

    localparam int ZC_W   = $clog2(MAX_ZEROS + 1);
    localparam int ACC_W  = MAX_ZEROS + 1;
    localparam int CMP_W  = (ACC_W + 1 > grld_pkg::LEN_W) ? ACC_W + 1 : grld_pkg::LEN_W;
    localparam int AREA_W = (PIXEL_BITS < grld_pkg::PIX_W) ? PIXEL_BITS : grld_pkg::PIX_W;
    localparam logic [grld_pkg::PIX_W-1:0] AREA_MASK =
        {grld_pkg::PIX_W{1'b1}} >> (grld_pkg::PIX_W - AREA_W);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SHORT,
        PH_ZEROS,
        PH_SUFFIX
    } phase_t;

    // configuration
    logic [grld_pkg::PIX_W-1:0] pixel_count_reg;
    logic                       gray_mode_reg;

    // decoder state
    logic                          have_color_reg, have_color_next;
    logic                          color_reg, color_next;
    phase_t                        phase_reg, phase_next;
    logic [ZC_W-1:0]               zero_count_reg, zero_count_next;
    logic [ZC_W-1:0]               suffix_left_reg, suffix_left_next;
    logic [ACC_W-1:0]              accum_reg, accum_next;
    logic [grld_pkg::LEN_W-1:0]    budget_reg, budget_next;
    logic                          finished_reg, finished_next;
    logic [7:0]                    shift_reg, shift_next;
    logic [grld_pkg::BITS_W-1:0]   bits_left_reg, bits_left_next;

    // run buffers
    logic                  pend_valid_reg, pend_valid_next;
    grld_pkg::run_word_t   pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    grld_pkg::run_word_t   out_reg, out_next;

    logic                       bit_val;
    logic                       emit;
    logic                       prefix_err;
    logic [CMP_W-1:0]           run_len;
    logic [CMP_W-1:0]           budget_ext;
    logic                       clip;
    logic [ACC_W-1:0]           accum_shift;
    logic [ZC_W-1:0]            suffix_dec;
    logic [grld_pkg::PIX_W-1:0] area;
    grld_pkg::run_word_t        run_desc;

    assign bit_val     = (shift_reg & grld_pkg::TOP_BIT) != 8'h00;
    assign accum_shift = {accum_reg[ACC_W-2:0], bit_val};
    assign suffix_dec  = (suffix_left_reg != '0) ? suffix_left_reg - ZC_W'(1) : '0;
    assign area        = pixel_count_reg & AREA_MASK;
    assign budget_ext  = CMP_W'(budget_reg);

    // decode of the current bit: does it finish a run, and with what length
    always_comb
    begin
        emit       = 1'b0;
        prefix_err = 1'b0;
        run_len    = '0;
        case (phase_reg)
            PH_SHORT:
            begin
                emit    = 1'b1;
                run_len = CMP_W'(bit_val) + CMP_W'(1);
            end
            PH_ZEROS:
            begin
                if (!bit_val && (zero_count_reg >= ZC_W'(MAX_ZEROS)))
                begin
                    emit       = 1'b1;
                    prefix_err = 1'b1;
                end
            end
            PH_SUFFIX:
            begin
                if (suffix_dec == '0)
                begin
                    emit    = 1'b1;
                    run_len = CMP_W'(accum_shift) + CMP_W'(1);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign clip = prefix_err || (run_len >= budget_ext);

    always_comb
    begin
        run_desc.run_color    = color_reg;
        run_desc.run_length   = clip ? budget_reg : run_len[grld_pkg::LEN_W-1:0];
        run_desc.run_last     = 1'b0;
        run_desc.image_done   = clip;
        run_desc.length_error = prefix_err || (run_len > budget_ext);
    end

    always_comb
    begin
        have_color_next  = have_color_reg;
        color_next       = color_reg;
        phase_next       = phase_reg;
        zero_count_next  = zero_count_reg;
        suffix_left_next = suffix_left_reg;
        accum_next       = accum_reg;
        budget_next      = budget_reg;
        finished_next    = finished_reg;
        shift_next       = shift_reg;
        bits_left_next   = bits_left_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_next         = out_reg;

        if (cmd.load)
        begin
            if (in_word.frame_start)
            begin
                budget_next      = gray_mode_reg ? {area, 2'b00} : {2'b00, area};
                color_next       = (in_word.stream_byte & grld_pkg::TOP_BIT) != 8'h00;
                have_color_next  = 1'b1;
                phase_next       = PH_FIRST;
                zero_count_next  = '0;
                suffix_left_next = '0;
                accum_next       = '0;
                finished_next    = (area == '0);
                shift_next       = {in_word.stream_byte[6:0], 1'b0};
                bits_left_next   = grld_pkg::BITS_W'(7);
            end
            else
            begin
                shift_next     = in_word.stream_byte;
                bits_left_next = grld_pkg::BITS_W'(8);
            end
        end
        else if (cmd.step)
        begin
            shift_next     = {shift_reg[6:0], 1'b0};
            bits_left_next = bits_left_reg - grld_pkg::BITS_W'(1);
            case (phase_reg)
                PH_FIRST:
                begin
                    if (bit_val)
                        phase_next = PH_SHORT;
                    else
                    begin
                        zero_count_next = ZC_W'(1);
                        phase_next      = PH_ZEROS;
                    end
                end
                PH_ZEROS:
                begin
                    if (bit_val)
                    begin
                        suffix_left_next = zero_count_reg;
                        accum_next       = ACC_W'(1);
                        phase_next       = PH_SUFFIX;
                    end
                    else if (!prefix_err)
                        zero_count_next = zero_count_reg + ZC_W'(1);
                end
                PH_SUFFIX:
                begin
                    accum_next       = accum_shift;
                    suffix_left_next = suffix_dec;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (emit)
            begin
                budget_next   = clip ? '0 : budget_reg - run_len[grld_pkg::LEN_W-1:0];
                finished_next = clip;
                color_next    = !color_reg;
                phase_next    = PH_FIRST;
                // older descriptor is known not to be the last of the word
                if (pend_valid_reg)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                end
                pend_next       = run_desc;
                pend_valid_next = 1'b1;
            end
        end
        else if (cmd.flush)
        begin
            out_next          = pend_reg;
            out_next.run_last = 1'b1;
            out_valid_next    = 1'b1;
            pend_valid_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= grld_pkg::PIX_W'(1);
            gray_mode_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_word.index)
                grld_pkg::REG_PIXEL_COUNT: pixel_count_reg <= cfg_word.value;
                grld_pkg::REG_GRAY_MODE:   gray_mode_reg   <= cfg_word.value[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_color_reg  <= 1'b0;
            color_reg       <= 1'b0;
            phase_reg       <= PH_FIRST;
            zero_count_reg  <= '0;
            suffix_left_reg <= '0;
            accum_reg       <= '0;
            budget_reg      <= '0;
            finished_reg    <= 1'b0;
            bits_left_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            have_color_reg  <= have_color_next;
            color_reg       <= color_next;
            phase_reg       <= phase_next;
            zero_count_reg  <= zero_count_next;
            suffix_left_reg <= suffix_left_next;
            accum_reg       <= accum_next;
            budget_reg      <= budget_next;
            finished_reg    <= finished_next;
            bits_left_reg   <= bits_left_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    always_comb
    begin
        stat.busy       = have_color_reg && !finished_reg && (bits_left_reg != '0);
        stat.emit       = emit;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

@@ hdl/gamma_run_length_decoder.sv @@
// gamma run-length decoder top level: one input word is one stream byte
// the last run of a word is flushed out once all of the word's code bits have been stepped
// a new word is accepted only after the previous word's last run is flushed; one bit per cycle
// runs leave through a one-deep output register; backpressure stalls bit steps
// rst_n is asynchronous, active low; clears decoder state, pixel_count reads 1
// depends on grld_pkg, grld_stream_if, grld_ctrl, grld_dp
module gamma_run_length_decoder #(
    parameter int MAX_ZEROS  = 24,
    parameter int PIXEL_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    grld_stream_if.sink   stream,
    grld_stream_if.sink   cfg,
    grld_stream_if.source runs
);

    grld_pkg::cmd_t  cmd;
    grld_pkg::stat_t stat;
    logic            in_ready;

    assign stream.ready = in_ready;
    assign cfg.ready    = 1'b1;

    grld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    grld_dp #(
        .MAX_ZEROS  (MAX_ZEROS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (stream.data),
        .cfg_wr    (cfg.valid && cfg.ready),
        .cfg_word  (cfg.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (runs.valid),
        .out_ready (runs.ready),
        .out_word  (runs.data)
    );

    // bits are stepped only while the word still has code bits to decode
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> stat.busy)
        else $error("bit step with no code bits left");

    // a finished run never overwrites a descriptor the sink has not taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.emit && stat.pend_valid) || cmd.flush |-> stat.out_free)
        else $error("descriptor pushed into a full output register");

    // a new word is taken only after the previous word's last run is flushed
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        stream.ready |-> !stat.pend_valid && !stat.busy)
        else $error("input ready while a word is still in work");

    a_load_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !stream.ready)
        else $error("input ready held after a word was accepted");

endmodule

@@ dv/grld_run_checker.sv @@
// checker for the gamma run-length decoder: watches the stream, cfg and runs channels
// keeps its own bit-serial decoder to predict run descriptors; depends on grld_pkg
module grld_run_checker #(
    parameter int MAX_ZEROS  = 24,
    parameter int PIXEL_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stream_valid,
    input  logic                stream_ready,
    input  grld_pkg::in_word_t  stream_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  grld_pkg::cfg_word_t cfg_data,
    input  logic                runs_valid,
    input  logic                runs_ready,
    input  grld_pkg::run_word_t runs_data,
    output int unsigned         fail_count,
    output int unsigned         pending,
    output int unsigned         runs_checked
);

    typedef enum logic [1:0] {PH_FIRST, PH_SHORT, PH_ZEROS, PH_SUFFIX} code_phase_t;

    // register shadows, updated on each cfg write and read at each frame start
    logic [grld_pkg::PIX_W-1:0] pixel_count;
    logic                       gray_mode;

    logic                       framed;
    logic                       color;
    logic                       done;
    code_phase_t                phase;
    logic [4:0]                 zeros;
    logic [4:0]                 suffix;
    logic [grld_pkg::LEN_W-1:0] accum;
    logic [grld_pkg::LEN_W-1:0] budget;

    grld_pkg::run_word_t pending_runs[$];

    function automatic grld_pkg::run_word_t close_run(logic [grld_pkg::LEN_W-1:0] len,
                                                      logic prefix_err);
        grld_pkg::run_word_t r;
        r.length_error = prefix_err;
        if (prefix_err || len >= budget)
        begin
            if (len > budget)
                r.length_error = 1'b1;
            len    = budget;
            budget = '0;
            done   = 1'b1;
        end
        else
        begin
            budget = budget - len;
        end
        r.run_color  = color;
        r.run_length = len;
        r.run_last   = 1'b0;
        r.image_done = done;
        color = ~color;
        phase = PH_FIRST;
        return r;
    endfunction

    function automatic void decode_word(grld_pkg::in_word_t w);
        logic [7:0]                 sr;
        logic [grld_pkg::LEN_W-1:0] area;
        logic                       b;
        int                         nbits;
        grld_pkg::run_word_t        made[$];
        sr    = w.stream_byte;
        nbits = 8;
        if (w.frame_start)
        begin
            area   = grld_pkg::LEN_W'(pixel_count)
                     & grld_pkg::LEN_W'((64'd1 << PIXEL_BITS) - 1);
            budget = gray_mode ? {area[grld_pkg::LEN_W-3:0], 2'b00} : area;
            color  = sr[7];
            framed = 1'b1;
            phase  = PH_FIRST;
            zeros  = '0;
            suffix = '0;
            accum  = '0;
            done   = (budget == '0);
            sr     = sr << 1;
            nbits  = 7;
        end
        if (!framed || done)
            return;
        while (nbits > 0 && !done)
        begin
            b     = sr[7];
            sr    = sr << 1;
            nbits = nbits - 1;
            case (phase)
                PH_FIRST:
                begin
                    if (b)
                        phase = PH_SHORT;
                    else
                    begin
                        zeros = 5'd1;
                        phase = PH_ZEROS;
                    end
                end
                PH_SHORT:
                    made.push_back(close_run(grld_pkg::LEN_W'(b) + grld_pkg::LEN_W'(1),
                                             1'b0));
                PH_ZEROS:
                begin
                    if (b)
                    begin
                        suffix = zeros;
                        accum  = grld_pkg::LEN_W'(1);
                        phase  = PH_SUFFIX;
                    end
                    // too many zeros: the rest of the budget goes out flagged
                    else if (int'(zeros) >= MAX_ZEROS)
                        made.push_back(close_run('0, 1'b1));
                    else
                        zeros = zeros + 5'd1;
                end
                default:
                begin
                    accum = {accum[grld_pkg::LEN_W-2:0], b};
                    if (suffix > 0)
                        suffix = suffix - 5'd1;
                    if (suffix == 0)
                        made.push_back(close_run(accum + grld_pkg::LEN_W'(1), 1'b0));
                end
            endcase
        end
        if (made.size() > 0)
            made[made.size() - 1].run_last = 1'b1;
        foreach (made[i])
            pending_runs.push_back(made[i]);
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $display("%0t: run %0d %s expected %0h got %0h", $time, runs_checked, name,
                     want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        grld_pkg::run_word_t want;
        if (!rst_n)
        begin
            pixel_count  = grld_pkg::PIX_W'(1);
            gray_mode    = 1'b0;
            framed       = 1'b0;
            color        = 1'b0;
            done         = 1'b0;
            phase        = PH_FIRST;
            zeros        = '0;
            suffix       = '0;
            accum        = '0;
            budget       = '0;
            pending_runs.delete();
            fail_count   = 0;
            runs_checked = 0;
            pending      = 0;
        end
        else
        begin
            // a frame start in the same cycle as a write still sees the old registers
            if (stream_valid && stream_ready)
                decode_word(stream_data);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data.index == grld_pkg::REG_PIXEL_COUNT)
                    pixel_count = cfg_data.value;
                else if (cfg_data.index == grld_pkg::REG_GRAY_MODE)
                    gray_mode = cfg_data.value[0];
            end
            if (runs_valid && runs_ready)
            begin
                if (pending_runs.size() == 0)
                begin
                    $display("%0t: unexpected run color %0d length %0h", $time,
                             runs_data.run_color, runs_data.run_length);
                    fail_count++;
                end
                else
                begin
                    want = pending_runs.pop_front();
                    check_field("run_color", want.run_color, runs_data.run_color);
                    check_field("run_length", want.run_length, runs_data.run_length);
                    check_field("run_last", want.run_last, runs_data.run_last);
                    check_field("image_done", want.image_done, runs_data.image_done);
                    check_field("length_error", want.length_error, runs_data.length_error);
                    runs_checked++;
                end
            end
            pending = pending_runs.size();
        end
    end

endmodule

@@ dv/gamma_run_length_decoder_tb.sv @@
// testbench top for the gamma run-length decoder: clock, reset, stream and cfg stimulus
// depends on grld_pkg, grld_stream_if, gamma_run_length_decoder and grld_run_checker
module gamma_run_length_decoder_tb;

    localparam int MAX_ZEROS   = 24;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    grld_stream_if #(.T(grld_pkg::in_word_t))  stream_ch ();
    grld_stream_if #(.T(grld_pkg::cfg_word_t)) cfg_ch ();
    grld_stream_if #(.T(grld_pkg::run_word_t)) runs_ch ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned runs_checked;

    int unsigned words_sent   = 0;
    int unsigned frames_sent  = 0;
    int unsigned reg_writes   = 0;
    int unsigned idle_cycles  = 0;
    bit          quiet        = 1'b0;
    bit          hold_request = 1'b0;
    bit          held         = 1'b0;
    logic [grld_pkg::PIX_W-1:0] cur_px   = grld_pkg::PIX_W'(1);
    logic                       cur_gray = 1'b0;
    bit                         code_bits[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gamma_run_length_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stream(stream_ch),
        .cfg   (cfg_ch),
        .runs  (runs_ch)
    );

    grld_run_checker #(.MAX_ZEROS(MAX_ZEROS)) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream_valid(stream_ch.valid),
        .stream_ready(stream_ch.ready),
        .stream_data (stream_ch.data),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_data    (cfg_ch.data),
        .runs_valid  (runs_ch.valid),
        .runs_ready  (runs_ch.ready),
        .runs_data   (runs_ch.data),
        .fail_count  (fail_count),
        .pending     (pending),
        .runs_checked(runs_checked)
    );

    // run receiver: random stalls, one long hold on request, always ready at the end
    initial
    begin
        runs_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                runs_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                runs_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                runs_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                runs_ch.ready <= 1'b1;
            end
            else
            begin
                runs_ch.ready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((stream_ch.valid && stream_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (runs_ch.valid && runs_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("gamma_run_length_decoder regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_word(logic [7:0] value, logic start);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            stream_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clk);
        end
        @(negedge clk);
        stream_ch.valid <= 1'b1;
        stream_ch.data  <= grld_pkg::in_word_t'{stream_byte: value, frame_start: start};
        do @(posedge clk); while (!stream_ch.ready);
        words_sent++;
    endtask

    // drop valid and wait until every predicted run is out and the decoder has gone idle
    task automatic settle();
        @(negedge clk);
        stream_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [grld_pkg::CFG_IDX_W-1:0] idx,
                             logic [grld_pkg::PIX_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= grld_pkg::cfg_word_t'{index: idx, value: value};
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        reg_writes++;
        if (idx == grld_pkg::REG_PIXEL_COUNT)
            cur_px = value;
        else
            cur_gray = value[0];
    endtask

    task automatic set_config(logic [grld_pkg::PIX_W-1:0] px, logic gray);
        write_reg(grld_pkg::REG_PIXEL_COUNT, px);
        write_reg(grld_pkg::REG_GRAY_MODE, grld_pkg::PIX_W'(gray));
    endtask

    // gamma code for one run length, 1 .. 2^25
    function automatic void add_run(int unsigned len);
        int unsigned v;
        int          z;
        if (len <= 2)
        begin
            code_bits.push_back(1'b1);
            code_bits.push_back(len == 2);
        end
        else
        begin
            v = len - 1;
            z = 0;
            while ((v >> (z + 1)) != 0)
                z++;
            repeat (z) code_bits.push_back(1'b0);
            code_bits.push_back(1'b1);
            for (int i = z - 1; i >= 0; i--)
                code_bits.push_back(v[i]);
        end
    endfunction

    function automatic void add_bad_prefix();
        repeat (MAX_ZEROS + 1) code_bits.push_back(1'b0);
    endfunction

    // pack the queued code bits MSB first behind the colour bit, random padding
    task automatic send_frame(logic color);
        logic [7:0] b;
        bit         first;
        first = 1'b1;
        do
        begin
            b = '0;
            for (int i = (first ? 6 : 7); i >= 0; i--)
                b[i] = (code_bits.size() != 0) ? code_bits.pop_front()
                                               : 1'($urandom_range(0, 1));
            if (first)
                b[7] = color;
            send_word(b, first);
            first = 1'b0;
        end
        while (code_bits.size() != 0);
        frames_sent++;
    endtask

    task automatic random_frame();
        int unsigned budget;
        int unsigned total;
        int unsigned len;
        int          pick;
        int          nruns;
        if ($urandom_range(0, 3) == 0)
        begin
            settle();
            pick = $urandom_range(0, 19);
            set_config(pick == 0 ? grld_pkg::PIX_W'(0) :
                       pick == 1 ? grld_pkg::PIX_W'($urandom_range(1, 24'hFFFFFF)) :
                       pick == 2 ? grld_pkg::PIX_W'(24'hFFFFFF) :
                                   grld_pkg::PIX_W'($urandom_range(1, 48)),
                       1'($urandom_range(0, 1)));
            // stray words before the next frame start still see the old frame
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_word(8'($urandom), 1'b0);
        end
        budget = cur_gray ? cur_px * 4 : cur_px;
        total  = 0;
        nruns  = 0;
        while (total < budget && nruns < 16)
        begin
            pick = $urandom_range(0, 23);
            if (pick < 12)
                len = $urandom_range(1, 4);
            else if (pick < 17)
                len = $urandom_range(5, 40);
            else if (pick < 20)
                len = $urandom_range(41, 3000);
            else if (pick == 20)
                len = $urandom_range(1, 1 << 25);
            else
                len = (budget - total > (1 << 25)) ? (1 << 25) : budget - total;
            add_run(len);
            total += len;
            nruns++;
            if ($urandom_range(0, 19) == 0)
                break;
        end
        if ($urandom_range(0, 9) == 0)
            add_bad_prefix();
        send_frame(1'($urandom_range(0, 1)));
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0);
        if ($urandom_range(0, 11) == 0)
        begin
            send_word(8'($urandom), 1'b1);
            repeat ($urandom_range(1, 2)) send_word(8'($urandom), 1'b0);
        end
    endtask

    initial
    begin
        stream_ch.valid = 1'b0;
        stream_ch.data  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        rst_n           = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // words ahead of any frame start are dropped
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        // reset area of one pixel: a length-one run fills it, later words are dropped
        send_word(8'hC0, 1'b1);
        send_word(8'hFF, 1'b0);
        settle();
        set_config(grld_pkg::PIX_W'(0), 1'b0);
        send_word(8'h7F, 1'b1);
        send_word(8'hAA, 1'b0);
        settle();
        // three short runs out of one word, then a run split across words
        set_config(grld_pkg::PIX_W'(40), 1'b0);
        send_word(8'h7F, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        settle();
        // overrun of the budget gets clipped
        set_config(grld_pkg::PIX_W'(5), 1'b0);
        add_run(3);
        add_run(4);
        send_frame(1'b0);
        settle();
        // largest area in gray, longest run, then an overlong zero prefix
        set_config(grld_pkg::PIX_W'(24'hFFFFFF), 1'b1);
        add_run(1 << 25);
        add_run(3);
        add_bad_prefix();
        send_frame(1'b1);
        settle();
        // gray budget filled exactly
        set_config(grld_pkg::PIX_W'(3), 1'b1);
        add_run(12);
        send_frame(1'b0);

        while (words_sent < 160)
        begin
            if (!held && words_sent >= 70)
            begin
                // long receiver hold while the sender keeps pushing short runs
                settle();
                set_config(grld_pkg::PIX_W'(200), 1'b0);
                hold_request = 1'b1;
                held = 1'b1;
                repeat (24) add_run($urandom_range(1, 2));
                send_frame(1'b1);
            end
            if (words_sent >= 140)
                quiet = 1'b1;
            random_frame();
        end

        settle();
        repeat (30) @(negedge clk);
        if (pending != 0)
            $display("%0t: %0d expected runs never arrived", $time, pending);
        $display("covered %0d stream words in %0d frames, %0d register writes, one long stall",
                 words_sent, frames_sent, reg_writes);
        $display("compared %0d run descriptors, %0d mismatches", runs_checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("gamma_run_length_decoder regression: pass");
        else
            $display("gamma_run_length_decoder regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/grld_pkg.sv
hdl/grld_stream_if.sv
hdl/grld_ctrl.sv
hdl/grld_dp.sv
hdl/gamma_run_length_decoder.sv
dv/grld_run_checker.sv
dv/gamma_run_length_decoder_tb.sv
